@@ hdl/tfhv_pkg.sv @@
// ----------------------------------------------------------------------------
// tfhv_pkg
// Types and constants shared by the tensor file header validator.
// ----------------------------------------------------------------------------
package tfhv_pkg;

  localparam logic [31:0] FILE_MAGIC  = 32'h4158_5430;
  localparam logic [62:0] INT63_MAX   = {63{1'b1}};
  localparam logic [31:0] DEFAULT_CAP = 32'h8000_0000;

  // status codes
  localparam logic [3:0] STAT_OK        = 4'd0;
  localparam logic [3:0] STAT_BAD_MAGIC = 4'd1;
  localparam logic [3:0] STAT_BAD_DTYPE = 4'd2;
  localparam logic [3:0] STAT_BAD_NDIM  = 4'd3;
  localparam logic [3:0] STAT_BAD_DIM   = 4'd4;
  localparam logic [3:0] STAT_COUNT_OVF = 4'd5;
  localparam logic [3:0] STAT_TOO_LARGE = 4'd6;
  localparam logic [3:0] STAT_TRUNCATED = 4'd7;
  localparam logic [3:0] STAT_IGNORED   = 4'd8;

  // register indexes (paddr[4:3])
  localparam logic [1:0] REG_DTYPE_COUNT = 2'd0;
  localparam logic [1:0] REG_ELEM_SIZE   = 2'd1;
  localparam logic [1:0] REG_MAX_BYTES   = 2'd2;

  typedef enum logic [6:0] {
    PH_MAGIC   = 7'b0000001,
    PH_DTYPE   = 7'b0000010,
    PH_NDIM    = 7'b0000100,
    PH_DIMS    = 7'b0001000,
    PH_PAYLOAD = 7'b0010000,
    PH_DONE    = 7'b0100000,
    PH_HALT    = 7'b1000000
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'b001,
    ST_DIM_MUL  = 3'b010,
    ST_SIZE_MUL = 3'b100
  } fsm_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        payload_valid;
    logic [7:0]  payload_out;
    logic        tensor_done;
    logic [62:0] element_count;
    logic [3:0]  dtype_out;
    logic [31:0] payload_bytes;
  } result_t;

endpackage

@@ hdl/tfhv_byte_if.sv @@
// ----------------------------------------------------------------------------
// tfhv_byte_if
// Input byte channel: one file byte per beat with start and end markers.
// ----------------------------------------------------------------------------
interface tfhv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_marker;
  logic       end_marker;

  modport source (output valid, data_byte, start_marker, end_marker, input ready);
  modport sink   (input valid, data_byte, start_marker, end_marker, output ready);
endinterface

@@ hdl/tfhv_result_if.sv @@
// ----------------------------------------------------------------------------
// tfhv_result_if
// Result channel: one status beat per accepted input byte.
// ----------------------------------------------------------------------------
interface tfhv_result_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic        payload_valid;
  logic [7:0]  payload_out;
  logic        tensor_done;
  logic [62:0] element_count;
  logic [3:0]  dtype_out;
  logic [31:0] payload_bytes;

  modport source (output valid, status, payload_valid, payload_out, tensor_done,
                  element_count, dtype_out, payload_bytes, input ready);
  modport sink   (input valid, status, payload_valid, payload_out, tensor_done,
                  element_count, dtype_out, payload_bytes, output ready);
endinterface

@@ hdl/tensor_file_header_validator_core.sv @@
// ----------------------------------------------------------------------------
// tensor_file_header_validator_core
// Parses a tensor file header byte by byte, sizes the payload and passes it on.
// ----------------------------------------------------------------------------
// An accepted byte's result is registered in the result register. The last
// byte of a dimension first passes through the shared shift-add multiplier
// (early exit on overflow); the byte that ends the header also passes through
// the element size multiply. All other bytes: one per cycle while the result register is free.
// Reset (rst, synchronous): parser back to magic, config to defaults,
// result register emptied.
module tensor_file_header_validator_core
  import tfhv_pkg::*;
#(
  parameter int MAX_DIMS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  tfhv_byte_if.sink            file_ch,
  tfhv_result_if.source        result_ch,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);

  // configuration
  logic [4:0]  dtype_count;
  logic [63:0] elem_size_table;
  logic [31:0] max_tensor_bytes;

  // parser state
  phase_t      phase, phase_next;
  logic [2:0]  field_byte_index, field_byte_index_next;
  logic [63:0] field_shift, field_shift_next;
  logic [3:0]  dtype_reg, dtype_reg_next;
  logic [3:0]  ndim_reg, ndim_reg_next;
  logic [3:0]  dim_index, dim_index_next;
  logic [62:0] count_reg, count_reg_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [31:0] total_reg, total_reg_next;

  // sequencer and shared multiplier
  fsm_t        fsm, fsm_next;
  logic [64:0] acc, acc_next;
  logic [62:0] mult_sh, mult_sh_next;
  logic [5:0]  steps, steps_next;
  logic        pend_end, pend_end_next;

  // result register
  result_t     res, res_next;
  logic        out_valid, out_valid_next;

  logic        in_fire, out_free, cfg_wr;
  logic [64:0] acc_step;
  logic [62:0] mul_limit;
  logic        step_ovf, mul_last;
  logic [3:0]  es;
  logic [4:0]  dtype_lim;
  logic [3:0]  dim_inc;
  logic [63:0] fsh_acc;
  logic [31:0] fld_v;
  logic        emit, end_flag;
  logic [3:0]  r_status;
  logic        r_pv, r_done;
  logic        shown;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign out_free = !out_valid || result_ch.ready;
  assign file_ch.ready = (fsm == ST_IDLE) && out_free;
  assign in_fire  = file_ch.valid && file_ch.ready;

  always_comb begin
    unique case (paddr[4:3])
      REG_DTYPE_COUNT: prdata = {59'd0, dtype_count};
      REG_ELEM_SIZE:   prdata = elem_size_table;
      REG_MAX_BYTES:   prdata = {32'd0, max_tensor_bytes};
      default:         prdata = 64'd0;
    endcase
  end

  // shared shift-add unit: count_reg times a multiplier scanned MSB first,
  // with a running compare against the limit
  assign mul_limit = (fsm == ST_SIZE_MUL) ? {31'd0, max_tensor_bytes} : INT63_MAX;
  assign acc_step  = {acc[63:0], 1'b0} + (mult_sh[62] ? {2'b00, count_reg} : 65'd0);
  assign step_ovf  = acc_step > {2'b00, mul_limit};
  assign mul_last  = step_ovf || (steps == 6'd0);

  assign es        = elem_size_table[{dtype_reg, 2'b00} +: 4];
  assign dtype_lim = (dtype_count > 5'd16) ? 5'd16 : dtype_count;

  always_comb begin
    phase_next            = phase;
    field_byte_index_next = field_byte_index;
    field_shift_next      = field_shift;
    dtype_reg_next        = dtype_reg;
    ndim_reg_next         = ndim_reg;
    dim_index_next        = dim_index;
    count_reg_next        = count_reg;
    bytes_left_next       = bytes_left;
    total_reg_next        = total_reg;
    fsm_next              = fsm;
    acc_next              = acc;
    mult_sh_next          = mult_sh;
    steps_next            = steps;
    pend_end_next         = pend_end;
    fsh_acc               = 64'd0;
    fld_v                 = 32'd0;
    dim_inc               = dim_index + 4'd1;
    emit                  = 1'b0;
    end_flag              = pend_end;
    r_status              = STAT_OK;
    r_pv                  = 1'b0;
    r_done                = 1'b0;

    unique case (fsm)
      ST_IDLE: begin
        if (in_fire) begin
          emit          = 1'b1;
          end_flag      = file_ch.end_marker;
          pend_end_next = file_ch.end_marker;
          if (file_ch.start_marker) begin
            phase_next            = PH_MAGIC;
            field_byte_index_next = 3'd0;
            field_shift_next      = 64'd0;
            dtype_reg_next        = 4'd0;
            ndim_reg_next         = 4'd0;
            dim_index_next        = 4'd0;
            count_reg_next        = 63'd1;
            bytes_left_next       = 32'd0;
            total_reg_next        = 32'd0;
          end
          unique case (phase_next)
            PH_MAGIC, PH_DTYPE, PH_NDIM: begin
              fsh_acc = field_shift_next |
                        ({56'd0, file_ch.data_byte} << {field_byte_index_next[1:0], 3'b000});
              if (field_byte_index_next < 3'd3) begin
                field_byte_index_next = field_byte_index_next + 3'd1;
                field_shift_next      = fsh_acc;
              end else begin
                fld_v                 = fsh_acc[31:0];
                field_byte_index_next = 3'd0;
                field_shift_next      = 64'd0;
                if (phase_next == PH_MAGIC) begin
                  if (fld_v != FILE_MAGIC) begin
                    r_status   = STAT_BAD_MAGIC;
                    phase_next = PH_HALT;
                  end else begin
                    phase_next = PH_DTYPE;
                  end
                end else if (phase_next == PH_DTYPE) begin
                  if (fld_v >= {27'd0, dtype_lim}) begin
                    r_status   = STAT_BAD_DTYPE;
                    phase_next = PH_HALT;
                  end else begin
                    dtype_reg_next = fld_v[3:0];
                    phase_next     = PH_NDIM;
                  end
                end else begin
                  if (fld_v > 32'(MAX_DIMS)) begin
                    r_status   = STAT_BAD_NDIM;
                    phase_next = PH_HALT;
                  end else begin
                    ndim_reg_next  = fld_v[3:0];
                    dim_index_next = 4'd0;
                    if (fld_v == 32'd0) begin
                      // empty shape: straight to sizing
                      emit         = 1'b0;
                      fsm_next     = ST_SIZE_MUL;
                      acc_next     = 65'd0;
                      mult_sh_next = {es, 59'd0};
                      steps_next   = 6'd3;
                    end else begin
                      phase_next = PH_DIMS;
                    end
                  end
                end
              end
            end
            PH_DIMS: begin
              fsh_acc = field_shift_next |
                        ({56'd0, file_ch.data_byte} << {field_byte_index_next, 3'b000});
              if (field_byte_index_next < 3'd7) begin
                field_byte_index_next = field_byte_index_next + 3'd1;
                field_shift_next      = fsh_acc;
              end else begin
                field_byte_index_next = 3'd0;
                field_shift_next      = 64'd0;
                if (fsh_acc == 64'd0 || fsh_acc[63]) begin
                  r_status   = STAT_BAD_DIM;
                  phase_next = PH_HALT;
                end else begin
                  emit         = 1'b0;
                  fsm_next     = ST_DIM_MUL;
                  acc_next     = 65'd0;
                  mult_sh_next = fsh_acc[62:0];
                  steps_next   = 6'd62;
                end
              end
            end
            PH_PAYLOAD: begin
              r_pv = 1'b1;
              if (bytes_left_next != 32'd0) begin
                bytes_left_next = bytes_left_next - 32'd1;
              end
              if (bytes_left_next == 32'd0) begin
                r_done     = 1'b1;
                phase_next = PH_DONE;
              end
            end
            default: begin
              r_status = STAT_IGNORED;
            end
          endcase
        end
      end
      ST_DIM_MUL: begin
        if (out_free) begin
          acc_next     = acc_step;
          mult_sh_next = {mult_sh[61:0], 1'b0};
          steps_next   = steps - 6'd1;
          if (mul_last) begin
            fsm_next = ST_IDLE;
            if (step_ovf) begin
              emit       = 1'b1;
              r_status   = STAT_COUNT_OVF;
              phase_next = PH_HALT;
            end else begin
              count_reg_next = acc_step[62:0];
              dim_index_next = dim_inc;
              if (dim_inc >= ndim_reg) begin
                fsm_next     = ST_SIZE_MUL;
                acc_next     = 65'd0;
                mult_sh_next = {es, 59'd0};
                steps_next   = 6'd3;
              end else begin
                emit = 1'b1;
              end
            end
          end
        end
      end
      ST_SIZE_MUL: begin
        if (out_free) begin
          acc_next     = acc_step;
          mult_sh_next = {mult_sh[61:0], 1'b0};
          steps_next   = steps - 6'd1;
          if (mul_last) begin
            fsm_next = ST_IDLE;
            emit     = 1'b1;
            if (step_ovf) begin
              r_status   = STAT_TOO_LARGE;
              phase_next = PH_HALT;
            end else begin
              total_reg_next  = acc_step[31:0];
              bytes_left_next = acc_step[31:0];
              if (acc_step[31:0] == 32'd0) begin
                r_done     = 1'b1;
                phase_next = PH_DONE;
              end else begin
                phase_next = PH_PAYLOAD;
              end
            end
          end
        end
      end
      default: begin
        fsm_next = ST_IDLE;
      end
    endcase

    // source ran dry before the tensor finished
    if (emit && end_flag && r_status == STAT_OK &&
        phase_next != PH_DONE && phase_next != PH_HALT) begin
      r_status   = STAT_TRUNCATED;
      phase_next = PH_HALT;
    end
  end

  assign shown = (phase_next == PH_PAYLOAD) || (phase_next == PH_DONE);

  always_comb begin
    res_next.status        = r_status;
    res_next.payload_valid = r_pv;
    res_next.payload_out   = r_pv ? file_ch.data_byte : 8'd0;
    res_next.tensor_done   = r_done;
    res_next.element_count = shown ? count_reg_next : 63'd0;
    res_next.dtype_out     = shown ? dtype_reg_next : 4'd0;
    res_next.payload_bytes = shown ? total_reg_next : 32'd0;
    out_valid_next         = emit || (out_valid && !result_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dtype_count      <= 5'd4;
      elem_size_table  <= 64'd4;
      max_tensor_bytes <= DEFAULT_CAP;
      phase            <= PH_MAGIC;
      field_byte_index <= 3'd0;
      field_shift      <= 64'd0;
      dtype_reg        <= 4'd0;
      ndim_reg         <= 4'd0;
      dim_index        <= 4'd0;
      count_reg        <= 63'd1;
      bytes_left       <= 32'd0;
      total_reg        <= 32'd0;
      fsm              <= ST_IDLE;
      pend_end         <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[4:3])
          REG_DTYPE_COUNT: dtype_count      <= pwdata[4:0];
          REG_ELEM_SIZE:   elem_size_table  <= pwdata;
          REG_MAX_BYTES:   max_tensor_bytes <= pwdata[31:0];
          default: ;
        endcase
      end
      phase            <= phase_next;
      field_byte_index <= field_byte_index_next;
      field_shift      <= field_shift_next;
      dtype_reg        <= dtype_reg_next;
      ndim_reg         <= ndim_reg_next;
      dim_index        <= dim_index_next;
      count_reg        <= count_reg_next;
      bytes_left       <= bytes_left_next;
      total_reg        <= total_reg_next;
      fsm              <= fsm_next;
      pend_end         <= pend_end_next;
      out_valid        <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    acc     <= acc_next;
    mult_sh <= mult_sh_next;
    steps   <= steps_next;
    if (emit) begin
      res <= res_next;
    end
  end

  assign result_ch.valid         = out_valid;
  assign result_ch.status        = res.status;
  assign result_ch.payload_valid = res.payload_valid;
  assign result_ch.payload_out   = res.payload_out;
  assign result_ch.tensor_done   = res.tensor_done;
  assign result_ch.element_count = res.element_count;
  assign result_ch.dtype_out     = res.dtype_out;
  assign result_ch.payload_bytes = res.payload_bytes;

  // no new byte while the multiplier is busy
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    fsm != ST_IDLE |-> !file_ch.ready)
    else $error("input ready while multiplier busy");

  // a beat is only accepted when the result register can take its result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> (!out_valid || result_ch.ready))
    else $error("input accepted with result register blocked");

  // completion is only reported on a clean beat
  a_done_ok: assert property (@(posedge clk) disable iff (rst)
    result_ch.valid && result_ch.tensor_done |-> result_ch.status == STAT_OK)
    else $error("tensor_done with error status");

  // payload only passes with ok or truncated status
  a_payload_status: assert property (@(posedge clk) disable iff (rst)
    result_ch.valid && result_ch.payload_valid |->
      (result_ch.status == STAT_OK || result_ch.status == STAT_TRUNCATED))
    else $error("payload beat with unexpected status");

  // the element size multiply finishes within its step budget
  a_mul_exit: assert property (@(posedge clk) disable iff (rst)
    fsm == ST_SIZE_MUL && steps == 6'd0 && out_free |=> fsm == ST_IDLE)
    else $error("size multiply overran");

endmodule
